// ===== hdl/asta_pkg.sv =====
// Shared types and constants of the ancestry score test accumulator.
`timescale 1ns / 1ps
`default_nettype none

package asta_pkg;

    localparam int Q_ONE         = 32768;
    localparam int SQRT_HALF_Q16 = 46341;
    localparam int SQRT_TWO_Q16  = 92682;

    localparam int PROB_W    = 16;
    localparam int NUM_W     = 34;
    localparam int DVD_W     = 50;
    localparam int ITER_W    = 120;
    localparam int SUMS_W    = 379;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 384;
    localparam int QDEPTH    = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_ACCUM  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [9:0]         locus;
        logic [1:0]         pop;
        logic               in_range;
        logic               is_diploid;
        logic               random_mating;
        logic [PROB_W-1:0]  theta_p;
        logic [PROB_W-1:0]  theta_m;
        logic [PROB_W-1:0]  p0;
        logic [PROB_W-1:0]  p1;
        logic [PROB_W-1:0]  p2;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/asta_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module asta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/asta_div.sv =====
// Radix-2 restoring divider that forms a rounded Q.15 ratio, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module asta_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [asta_pkg::NUM_W-1:0]    num,
    input  wire logic [asta_pkg::NUM_W-1:0]    den,
    output logic                               done,
    output logic [asta_pkg::DVD_W-1:0]         quotient
);

    localparam int NW = asta_pkg::NUM_W;
    localparam int DW = asta_pkg::DVD_W;
    localparam int CW = $clog2(DW);

    logic [NW:0]   rem_reg;
    logic [DW-1:0] dq_reg;
    logic [NW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW:0]   trial;
    logic          fits;

    assign trial = {rem_reg[NW-1:0], dq_reg[DW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= (DW'(num) << 15) + DW'(den >> 1);
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            dq_reg  <= {dq_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = (den_reg == '0) ? '0 : dq_reg;

endmodule

`default_nettype wire

// ===== hdl/asta_front.sv =====
// Input stage: takes beats, clamps probabilities, checks the entry range and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module asta_front #(
    parameter int NUM_LOCI = 1024,
    parameter int NUM_POPS = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [asta_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    input  wire logic                              hold,
    output logic                                   cmd_valid,
    output asta_pkg::cmd_t                         cmd,
    input  wire logic                              cmd_ready
);

    localparam int QD = asta_pkg::QDEPTH;
    localparam int PTRW = $clog2(QD);

    asta_pkg::cmd_t  fifo_reg [0:QD-1];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW:0]   count_reg;
    asta_pkg::cmd_t  in_cmd;
    logic            locus_ok;
    logic            pop_ok;
    logic            push;
    logic            pop;

    function automatic logic [15:0] clamp_q(input logic [15:0] v);
        return (v > 16'(asta_pkg::Q_ONE)) ? 16'(asta_pkg::Q_ONE) : v;
    endfunction

    assign locus_ok = (32'(s_tdata[9:0]) < 32'(NUM_LOCI));
    assign pop_ok   = (32'(s_tdata[11:10]) < 32'(NUM_POPS));

    always_comb begin
        in_cmd.op            = asta_pkg::op_t'(s_tuser);
        in_cmd.locus         = s_tdata[9:0];
        in_cmd.pop           = s_tdata[11:10];
        in_cmd.is_diploid    = s_tdata[12];
        in_cmd.random_mating = s_tdata[13];
        in_cmd.theta_p       = clamp_q(s_tdata[29:14]);
        in_cmd.theta_m       = clamp_q(s_tdata[45:30]);
        in_cmd.p0            = clamp_q(s_tdata[61:46]);
        in_cmd.p1            = clamp_q(s_tdata[77:62]);
        in_cmd.p2            = clamp_q(s_tdata[93:78]);
        if (asta_pkg::op_t'(s_tuser) == asta_pkg::OP_ACCUM) begin
            in_cmd.in_range = locus_ok;
        end else begin
            in_cmd.in_range = locus_ok && pop_ok;
        end
    end

    assign s_tready  = !hold && (count_reg != (PTRW + 1)'(QD));
    assign cmd_valid = (count_reg != '0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/asta_back.sv =====
// Execution stage: clear sweeps, updates with a shared multiplier and two dividers, accumulate, read.
`timescale 1ns / 1ps
`default_nettype none

module asta_back #(
    parameter int NUM_LOCI = 1024,
    parameter int NUM_POPS = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cmd_valid,
    input  wire asta_pkg::cmd_t                 cmd,
    output logic                                cmd_ready,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [asta_pkg::SUMS_W-1:0]         res_data,
    output logic                                init_busy
);

    localparam int ENTRIES = NUM_LOCI * NUM_POPS;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = (NUM_POPS > 1) ? $clog2(NUM_POPS) : 1;
    localparam int NW = asta_pkg::NUM_W;
    localparam int DW = asta_pkg::DVD_W;

    typedef enum logic [13:0] {
        ST_INIT      = 14'b00000000000001,
        ST_IDLE      = 14'b00000000000010,
        ST_CLEAR     = 14'b00000000000100,
        ST_RD_WAIT   = 14'b00000000001000,
        ST_RD_OUT    = 14'b00000000010000,
        ST_UPD_MUL   = 14'b00000000100000,
        ST_UPD_FORM  = 14'b00000001000000,
        ST_UPD_START = 14'b00000010000000,
        ST_UPD_DIV   = 14'b00000100000000,
        ST_UPD_WRITE = 14'b00001000000000,
        ST_ACC_READ  = 14'b00010000000000,
        ST_ACC_MUL   = 14'b00100000000000,
        ST_ACC_SUM   = 14'b01000000000000,
        ST_ACC_WRITE = 14'b10000000000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    asta_pkg::cmd_t  cmd_reg;
    logic [3:0]      step_reg;
    logic [PW-1:0]   k_reg;
    logic [AW-1:0]   sweep_reg;
    logic            sweep_last;

    logic [51:0]     mp_reg [0:12];
    logic [30:0]     pi1_reg;
    logic signed [19:0] ds_reg;
    logic [19:0]     dv_reg;
    logic [19:0]     di_reg;
    logic [NW-1:0]   num_lo_reg;
    logic [NW-1:0]   num_hi_reg;
    logic [NW-1:0]   den_lo_reg;
    logic [NW-1:0]   den_hi_reg;
    logic [62:0]     sq_reg;

    logic [AW-1:0]   upd_addr;
    logic [AW-1:0]   acc_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            iter_we;
    logic            sum_we;
    logic [AW-1:0]   wr_addr;
    logic [asta_pkg::ITER_W-1:0] iter_wd;
    logic [asta_pkg::ITER_W-1:0] iter_rd;
    logic [asta_pkg::SUMS_W-1:0] sum_wd;
    logic [asta_pkg::SUMS_W-1:0] sum_rd;

    logic [19:0]     mul_a;
    logic [31:0]     mul_b;
    logic [51:0]     mul_p;
    logic [39:0]     abs_score;

    logic [15:0]     t1;
    logic [15:0]     q_t0;
    logic [15:0]     q_t1;
    logic [15:0]     q_p1;
    logic [NW-1:0]   p0e;
    logic [NW-1:0]   p1e;
    logic [NW-1:0]   p2e;
    logic [NW-1:0]   t0e;
    logic signed [19:0] x_d;
    logic signed [19:0] ds_d;
    logic [19:0]     dv_d;
    logic [19:0]     di_d;
    logic [NW-1:0]   num_lo_d;
    logic [NW-1:0]   num_hi_d;
    logic [NW-1:0]   den_lo_d;
    logic [NW-1:0]   den_hi_d;
    logic [64:0]     sq_full;

    logic            div_start;
    logic            div_lo_done;
    logic            div_hi_done;
    logic [DW-1:0]   q_lo;
    logic [DW-1:0]   q_hi;

    function automatic logic [39:0] sat_s40(input logic [39:0] a, input logic [19:0] b);
        logic [40:0] s;
        s = {a[39], a} + {{21{b[19]}}, b};
        if (s[40] != s[39]) begin
            return s[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        end
        return s[39:0];
    endfunction

    function automatic logic [39:0] sat_u40(input logic [39:0] a, input logic [19:0] b);
        logic [40:0] s;
        s = 41'(a) + 41'(b);
        return s[40] ? {40{1'b1}} : s[39:0];
    endfunction

    function automatic logic [62:0] sat_u63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        return s[63] ? {63{1'b1}} : s[62:0];
    endfunction

    function automatic logic [63:0] sat_s64(input logic [63:0] a, input logic [39:0] b);
        logic [64:0] s;
        s = {a[63], a} + {{25{b[39]}}, b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    assign upd_addr = AW'(32'(cmd_reg.locus) * 32'(NUM_POPS) + 32'(cmd_reg.pop));
    assign acc_addr = AW'(32'(cmd_reg.locus) * 32'(NUM_POPS) + 32'(k_reg));
    assign sweep_last = (sweep_reg == AW'(ENTRIES - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        asta_pkg::OP_CLEAR:  state_next = ST_CLEAR;
                        asta_pkg::OP_UPDATE: state_next = cmd.in_range ? ST_UPD_MUL : ST_IDLE;
                        asta_pkg::OP_ACCUM:  state_next = cmd.in_range ? ST_ACC_READ : ST_IDLE;
                        asta_pkg::OP_READ:   state_next = ST_RD_WAIT;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_WAIT: state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_MUL: begin
                if (step_reg == 4'd12) begin
                    state_next = ST_UPD_FORM;
                end
            end
            ST_UPD_FORM:  state_next = ST_UPD_START;
            ST_UPD_START: state_next = ST_UPD_DIV;
            ST_UPD_DIV: begin
                if (div_lo_done && div_hi_done) begin
                    state_next = ST_UPD_WRITE;
                end
            end
            ST_UPD_WRITE: state_next = ST_IDLE;
            ST_ACC_READ:  state_next = ST_ACC_MUL;
            ST_ACC_MUL: begin
                if (step_reg == 4'd2) begin
                    state_next = ST_ACC_SUM;
                end
            end
            ST_ACC_SUM:   state_next = ST_ACC_WRITE;
            ST_ACC_WRITE: begin
                state_next = (k_reg == PW'(NUM_POPS - 1)) ? ST_IDLE : ST_ACC_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            step_reg  <= '0;
            k_reg     <= '0;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_UPD_MUL || state_reg == ST_ACC_MUL) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
            if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
                sweep_reg <= sweep_reg + 1'b1;
            end else begin
                sweep_reg <= '0;
            end
            if (state_reg == ST_IDLE) begin
                k_reg <= '0;
            end else if (state_reg == ST_ACC_WRITE) begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    assign t1   = cmd_reg.random_mating ? cmd_reg.theta_m : cmd_reg.theta_p;
    assign q_t0 = 16'(17'(asta_pkg::Q_ONE) - 17'(cmd_reg.theta_p));
    assign q_t1 = 16'(17'(asta_pkg::Q_ONE) - 17'(t1));
    assign q_p1 = 16'(17'(asta_pkg::Q_ONE) - 17'(cmd_reg.p1));
    assign abs_score = iter_rd[39] ? (~iter_rd[39:0] + 40'd1) : iter_rd[39:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_ACC_MUL) begin
            case (step_reg)
                4'd0: begin
                    mul_a = abs_score[39:20];
                    mul_b = 32'(abs_score[39:20]);
                end
                4'd1: begin
                    mul_a = abs_score[39:20];
                    mul_b = 32'(abs_score[19:0]);
                end
                default: begin
                    mul_a = abs_score[19:0];
                    mul_b = 32'(abs_score[19:0]);
                end
            endcase
        end else begin
            case (step_reg)
                4'd0: begin
                    mul_a = 20'(cmd_reg.p1);
                    mul_b = 32'(q_p1);
                end
                4'd1: begin
                    mul_a = 20'(cmd_reg.p2);
                    mul_b = 32'(cmd_reg.p0);
                end
                4'd2: begin
                    mul_a = 20'(cmd_reg.theta_p);
                    mul_b = 32'(q_t0);
                end
                4'd3: begin
                    mul_a = 20'(t1);
                    mul_b = 32'(q_t1);
                end
                4'd4: begin
                    mul_a = 20'(cmd_reg.theta_p);
                    mul_b = 32'(t1);
                end
                4'd5: begin
                    mul_a = 20'(cmd_reg.theta_p);
                    mul_b = 32'(q_t1);
                end
                4'd6: begin
                    mul_a = 20'(t1);
                    mul_b = 32'(q_t0);
                end
                4'd7: begin
                    mul_a = 20'(q_t0);
                    mul_b = 32'(q_t1);
                end
                4'd8: begin
                    mul_a = 20'(asta_pkg::SQRT_HALF_Q16);
                    mul_b = 32'(cmd_reg.p1);
                end
                4'd9: begin
                    mul_a = 20'(asta_pkg::SQRT_TWO_Q16);
                    mul_b = 32'(cmd_reg.p1);
                end
                4'd10: begin
                    mul_a = 20'(asta_pkg::SQRT_HALF_Q16);
                    mul_b = 32'(pi1_reg);
                end
                4'd11: begin
                    mul_a = 20'(asta_pkg::SQRT_TWO_Q16);
                    mul_b = 32'(pi1_reg);
                end
                default: begin
                    mul_a = 20'(cmd_reg.p0);
                    mul_b = 32'(cmd_reg.p1);
                end
            endcase
        end
    end

    assign mul_p = 52'(mul_a) * 52'(mul_b);

    assign p0e = NW'(cmd_reg.p0);
    assign p1e = NW'(cmd_reg.p1);
    assign p2e = NW'(cmd_reg.p2);
    assign t0e = NW'(cmd_reg.theta_p);
    assign x_d = 20'(cmd_reg.p1) + (20'(cmd_reg.p2) << 1) - 20'(cmd_reg.theta_p) - 20'(t1);

    always_comb begin
        if (cmd_reg.is_diploid) begin
            ds_d     = (x_d + 20'sd1) >>> 1;
            dv_d     = 20'((36'(mp_reg[0]) + (36'(mp_reg[1]) << 2) + 36'd65536) >> 17);
            di_d     = 20'((36'(mp_reg[2]) + 36'(mp_reg[3]) + 36'd65536) >> 17);
            num_lo_d = (p0e << 16) + NW'(mp_reg[8]) + (p2e << 15);
            num_hi_d = (p0e << 16) + NW'(mp_reg[9]) + (p2e << 17);
            den_lo_d = (NW'(mp_reg[7]) << 1) + NW'((mp_reg[10] + 52'd16384) >> 15)
                       + NW'(mp_reg[4]);
            den_hi_d = (NW'(mp_reg[7]) << 1) + NW'((mp_reg[11] + 52'd16384) >> 15)
                       + (NW'(mp_reg[4]) << 2);
        end else begin
            ds_d     = 20'(cmd_reg.p1) - 20'(cmd_reg.theta_p);
            dv_d     = 20'((36'(mp_reg[12]) + 36'd16384) >> 15);
            di_d     = 20'((36'(mp_reg[2]) + 36'd16384) >> 15);
            num_lo_d = (p0e << 1) + p1e;
            num_hi_d = p0e + (p1e << 1);
            den_lo_d = (NW'(q_t0) << 1) + t0e;
            den_hi_d = NW'(asta_pkg::Q_ONE) + t0e;
        end
    end

    assign sq_full = (65'(mp_reg[0]) << 25) + (65'(mp_reg[1]) << 6)
                     + 65'((mp_reg[2] + 52'd16384) >> 15);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && cmd_valid) begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_UPD_MUL || state_reg == ST_ACC_MUL) begin
            mp_reg[step_reg] <= mul_p;
        end
        if (state_reg == ST_UPD_MUL && step_reg == 4'd7) begin
            pi1_reg <= 31'(mp_reg[5]) + 31'(mp_reg[6]);
        end
        if (state_reg == ST_UPD_FORM) begin
            ds_reg     <= ds_d;
            dv_reg     <= dv_d;
            di_reg     <= di_d;
            num_lo_reg <= num_lo_d;
            num_hi_reg <= num_hi_d;
            den_lo_reg <= den_lo_d;
            den_hi_reg <= den_hi_d;
        end
        if (state_reg == ST_ACC_SUM) begin
            sq_reg <= (sq_full[64:63] != 2'b00) ? {63{1'b1}} : sq_full[62:0];
        end
    end

    assign div_start = (state_reg == ST_UPD_START);

    asta_div u_div_lo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (num_lo_reg),
        .den      (den_lo_reg),
        .done     (div_lo_done),
        .quotient (q_lo)
    );

    asta_div u_div_hi (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (num_hi_reg),
        .den      (den_hi_reg),
        .done     (div_hi_done),
        .quotient (q_hi)
    );

    assign rd_en = (state_reg == ST_RD_WAIT) || (state_reg == ST_ACC_READ)
                   || (state_reg == ST_UPD_MUL && step_reg == 4'd0);
    assign rd_addr = (state_reg == ST_ACC_READ) ? acc_addr : upd_addr;

    assign iter_we = (state_reg == ST_INIT) || (state_reg == ST_CLEAR)
                     || (state_reg == ST_UPD_WRITE);
    assign sum_we  = (state_reg == ST_INIT) || (state_reg == ST_UPD_WRITE)
                     || (state_reg == ST_ACC_WRITE);

    always_comb begin
        if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            wr_addr = sweep_reg;
        end else if (state_reg == ST_ACC_WRITE) begin
            wr_addr = acc_addr;
        end else begin
            wr_addr = upd_addr;
        end
    end

    always_comb begin
        if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            iter_wd = '0;
        end else begin
            iter_wd = {sat_u40(iter_rd[119:80], di_reg),
                       sat_u40(iter_rd[79:40], dv_reg),
                       sat_s40(iter_rd[39:0], ds_reg)};
        end
    end

    always_comb begin
        sum_wd = sum_rd;
        if (state_reg == ST_INIT) begin
            sum_wd = '0;
        end else if (state_reg == ST_ACC_WRITE) begin
            sum_wd[63:0]    = sat_s64(sum_rd[63:0], iter_rd[39:0]);
            sum_wd[126:64]  = sat_u63(sum_rd[126:64], sq_reg);
            sum_wd[189:127] = sat_u63(sum_rd[189:127], 63'(iter_rd[79:40]));
            sum_wd[252:190] = sat_u63(sum_rd[252:190], 63'(iter_rd[119:80]));
        end else begin
            sum_wd[315:253] = sat_u63(sum_rd[315:253], 63'(q_lo));
            sum_wd[378:316] = sat_u63(sum_rd[378:316], 63'(q_hi));
        end
    end

    asta_ram #(
        .WIDTH (asta_pkg::ITER_W),
        .DEPTH (ENTRIES)
    ) u_iter_ram (
        .aclk  (aclk),
        .we    (iter_we),
        .waddr (wr_addr),
        .wdata (iter_wd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (iter_rd)
    );

    asta_ram #(
        .WIDTH (asta_pkg::SUMS_W),
        .DEPTH (ENTRIES)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (wr_addr),
        .wdata (sum_wd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (sum_rd)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RD_OUT);
    assign res_data  = cmd_reg.in_range ? sum_rd : '0;
    assign init_busy = (state_reg == ST_INIT);

endmodule

`default_nettype wire

// ===== hdl/ancestry_score_test_accumulator_unit.sv =====
// Top level of the ancestry score test accumulator: front queue, execution stage, output register.
//
//   Channel   Direction  Beat carries
//   s_        in         one command: opcode in s_tuser, entry and probabilities in s_tdata
//   m_        out        one set of entry sums, only for a read command
//
// An update runs the 13-step shared multiplier and then the two 50-step dividers; an
// accumulate reads, multiplies, sums and writes each population; a read fetches one entry.
// A clear sweeps all NUM_LOCI * NUM_POPS entries of the per-iteration store.
// After reset a pass clears all NUM_LOCI * NUM_POPS entries of both stores, s_tready low.
// A four-deep queue keeps s_tready high while the execution stage works, until it fills,
// and the output register holds a finished result while m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module ancestry_score_test_accumulator_unit #(
    parameter int NUM_LOCI = 1024,
    parameter int NUM_POPS = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // locus, pop_req, is_diploid, random_mating, theta_paternal, theta_maternal,
    // prob_zero_copies, prob_one_copy, prob_two_copies
    input  wire logic [asta_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // score_total, score_square_total, variance_total, information_total,
    // ratio_low_total, ratio_high_total
    output logic [asta_pkg::M_TDATA_W-1:0]         m_tdata
);

    asta_pkg::cmd_t                 cmd;
    logic                           cmd_valid;
    logic                           cmd_ready;
    logic                           res_valid;
    logic                           res_ready;
    logic [asta_pkg::SUMS_W-1:0]    res_data;
    logic                           init_busy;
    logic                           m_tvalid_reg;
    logic [asta_pkg::M_TDATA_W-1:0] m_tdata_reg;

    asta_front #(
        .NUM_LOCI (NUM_LOCI),
        .NUM_POPS (NUM_POPS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .hold      (init_busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    asta_back #(
        .NUM_LOCI (NUM_LOCI),
        .NUM_POPS (NUM_POPS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .init_busy (init_busy)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= asta_pkg::M_TDATA_W'(res_data);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== dv/asta_checker.sv =====
// Checker that predicts the accumulator's entry sums and compares every result beat.
`timescale 1ns / 1ps
`default_nettype none

module asta_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [asta_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [asta_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                  fail_count,
    output int                                  pending_reads
);

    localparam int ENTRY_CNT = 4096;
    localparam bit [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint ISC_HI = 64'sd549755813887;
    localparam longint ISC_LO = -64'sd549755813888;
    localparam bit [63:0] IU_HI = 64'd1099511627775;
    localparam bit [63:0] ONE_Q15 = 64'(asta_pkg::Q_ONE);

    typedef struct {
        bit [63:0] score;
        bit [62:0] square;
        bit [62:0] variance;
        bit [62:0] info;
        bit [62:0] ratio_lo;
        bit [62:0] ratio_hi;
    } entry_sums_t;

    longint    it_score [ENTRY_CNT];
    bit [63:0] it_var   [ENTRY_CNT];
    bit [63:0] it_info  [ENTRY_CNT];
    bit [63:0] rlo_sum  [ENTRY_CNT];
    bit [63:0] rhi_sum  [ENTRY_CNT];
    longint    sc_sum   [ENTRY_CNT];
    bit [63:0] sq_sum   [ENTRY_CNT];
    bit [63:0] var_sum  [ENTRY_CNT];
    bit [63:0] info_sum [ENTRY_CNT];

    entry_sums_t read_q[$];

    function automatic bit [63:0] clamp_prob(bit [15:0] v);
        return (64'(v) > ONE_Q15) ? ONE_Q15 : 64'(v);
    endfunction

    function automatic bit [63:0] sat_add63(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s > SAT63 || s < a) ? SAT63 : s;
    endfunction

    function automatic bit [63:0] sat_add40u(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s > IU_HI) ? IU_HI : s;
    endfunction

    function automatic longint sat_add40s(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ISC_HI) return ISC_HI;
        if (s < ISC_LO) return ISC_LO;
        return s;
    endfunction

    function automatic longint sat_add64s(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic bit [63:0] ratio_q15(bit [63:0] num, bit [63:0] den);
        if (den == 0) return 0;
        return ((num << 15) + (den >> 1)) / den;
    endfunction

    function automatic bit [63:0] square_q15(longint s);
        bit [63:0] a, hi, lo, r;
        a = (s < 0) ? 64'(-s) : 64'(s);
        hi = a >> 20;
        lo = a & 64'hFFFFF;
        r = ((hi * hi) << 25) + ((hi * lo) << 6) + ((lo * lo + 16384) >> 15);
        return (r > SAT63) ? SAT63 : r;
    endfunction

    function automatic bit [63:0] diploid_ratio(bit [63:0] p0, p1, p2, pi0, pi1, pi2,
                                                bit high);
        bit [63:0] sq, num, den;
        sq = high ? 64'(asta_pkg::SQRT_TWO_Q16) : 64'(asta_pkg::SQRT_HALF_Q16);
        num = (p0 << 16) + sq * p1 + (high ? (p2 << 17) : (p2 << 15));
        den = (pi0 << 1) + ((sq * pi1 + 16384) >> 15) + (high ? (pi2 << 2) : pi2);
        return ratio_q15(num, den);
    endfunction

    task automatic apply_update(int e, bit [asta_pkg::S_TDATA_W-1:0] d);
        bit [63:0] t0, tm, t1, p0, p1, p2, dv, di, rl, rh, pi0, pi1, pi2;
        longint x, ds;
        t0 = clamp_prob(d[29:14]);
        tm = clamp_prob(d[45:30]);
        p0 = clamp_prob(d[61:46]);
        p1 = clamp_prob(d[77:62]);
        p2 = clamp_prob(d[93:78]);
        if (d[12]) begin
            t1 = d[13] ? tm : t0;
            x = longint'(p1) + 2 * longint'(p2) - longint'(t0) - longint'(t1);
            ds = ((x + 1 + 131072) >>> 1) - 65536;
            dv = (p1 * (ONE_Q15 - p1) + 4 * p2 * p0 + 65536) >> 17;
            di = (t0 * (ONE_Q15 - t0) + t1 * (ONE_Q15 - t1) + 65536) >> 17;
            pi2 = t0 * t1;
            pi1 = t0 * (ONE_Q15 - t1) + t1 * (ONE_Q15 - t0);
            pi0 = (ONE_Q15 - t0) * (ONE_Q15 - t1);
            rl = diploid_ratio(p0, p1, p2, pi0, pi1, pi2, 1'b0);
            rh = diploid_ratio(p0, p1, p2, pi0, pi1, pi2, 1'b1);
        end else begin
            ds = longint'(p1) - longint'(t0);
            dv = (p0 * p1 + 16384) >> 15;
            di = (t0 * (ONE_Q15 - t0) + 16384) >> 15;
            rl = ratio_q15(2 * p0 + p1, 2 * (ONE_Q15 - t0) + t0);
            rh = ratio_q15(p0 + 2 * p1, ONE_Q15 + t0);
        end
        it_score[e] = sat_add40s(it_score[e], ds);
        it_var[e] = sat_add40u(it_var[e], dv);
        it_info[e] = sat_add40u(it_info[e], di);
        rlo_sum[e] = sat_add63(rlo_sum[e], rl);
        rhi_sum[e] = sat_add63(rhi_sum[e], rh);
    endtask

    task automatic apply_command(asta_pkg::op_t op, bit [asta_pkg::S_TDATA_W-1:0] d);
        int e, i;
        entry_sums_t r;
        e = int'(d[9:0]) * 4 + int'(d[11:10]);
        case (op)
            asta_pkg::OP_CLEAR: begin
                for (i = 0; i < ENTRY_CNT; i++) begin
                    it_score[i] = 0;
                    it_var[i] = 0;
                    it_info[i] = 0;
                end
            end
            asta_pkg::OP_UPDATE: begin
                apply_update(e, d);
            end
            asta_pkg::OP_ACCUM: begin
                for (i = int'(d[9:0]) * 4; i < int'(d[9:0]) * 4 + 4; i++) begin
                    sc_sum[i] = sat_add64s(sc_sum[i], it_score[i]);
                    var_sum[i] = sat_add63(var_sum[i], it_var[i]);
                    info_sum[i] = sat_add63(info_sum[i], it_info[i]);
                    sq_sum[i] = sat_add63(sq_sum[i], square_q15(it_score[i]));
                end
            end
            default: begin
                r.score = sc_sum[e];
                r.square = sq_sum[e][62:0];
                r.variance = var_sum[e][62:0];
                r.info = info_sum[e][62:0];
                r.ratio_lo = rlo_sum[e][62:0];
                r.ratio_hi = rhi_sum[e][62:0];
                read_q.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(string name, bit [63:0] want, bit [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_result(bit [asta_pkg::M_TDATA_W-1:0] d);
        entry_sums_t r;
        if (read_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result beat: %h", d);
        end else begin
            r = read_q.pop_front();
            check_field("score_total", r.score, d[63:0]);
            check_field("score_square_total", 64'(r.square), 64'(d[126:64]));
            check_field("variance_total", 64'(r.variance), 64'(d[189:127]));
            check_field("information_total", 64'(r.info), 64'(d[252:190]));
            check_field("ratio_low_total", 64'(r.ratio_lo), 64'(d[315:253]));
            check_field("ratio_high_total", 64'(r.ratio_hi), 64'(d[378:316]));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                apply_command(asta_pkg::op_t'(s_tuser), s_tdata);
            pending_reads = read_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top: stimulus for the score test accumulator and the final verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEM_TARGET = 1750;
    localparam logic [15:0] PROB_ONE = 16'(asta_pkg::Q_ONE);

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [asta_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]                     s_tuser = asta_pkg::OP_CLEAR;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [asta_pkg::M_TDATA_W-1:0] m_tdata;
    int                             fail_count;
    int                             pending_reads;
    int                             cycle_count = 0;
    int                             sent = 0;
    int                             burst_left = 0;
    int                             stall_mode = 0;

    ancestry_score_test_accumulator_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    asta_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_reads(pending_reads)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // The receiver switches between always ready, light stalls and heavy stalls.
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return PROB_ONE;
            2: return 16'($urandom_range(asta_pkg::Q_ONE + 1, 65535));
            default: return 16'($urandom_range(0, asta_pkg::Q_ONE));
        endcase
    endfunction

    task automatic send(asta_pkg::op_t op, int locus, int pop, bit dip, bit rm,
                        logic [15:0] tp, logic [15:0] tm, logic [15:0] p0,
                        logic [15:0] p1, logic [15:0] p2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, p2, p1, p0, tm, tp, rm, dip, 2'(pop), 10'(locus)};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_update(int locus, int pop);
        send(asta_pkg::OP_UPDATE, locus, pop, $urandom_range(0, 1), $urandom_range(0, 1),
             pick_prob(), pick_prob(), pick_prob(), pick_prob(), pick_prob());
    endtask

    task automatic run_random();
        int loci[4];
        int n, k, clears;
        clears = 0;
        while (sent < ITEM_TARGET) begin
            for (k = 0; k < 4; k++)
                loci[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 15);
            if (clears < 12 && $urandom_range(0, 5) == 0) begin
                send(asta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                clears++;
            end
            n = $urandom_range(3, 12);
            for (k = 0; k < n; k++)
                send_update(loci[$urandom_range(0, 3)], $urandom_range(0, 3));
            for (k = 0; k < 4; k++)
                if ($urandom_range(0, 3) != 0)
                    send(asta_pkg::OP_ACCUM, loci[k], 0, 0, 0, 0, 0, 0, 0, 0);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send(asta_pkg::OP_READ, loci[$urandom_range(0, 3)], $urandom_range(0, 3),
                     0, 0, 0, 0, 0, 0, 0);
            if ($urandom_range(0, 9) == 0)
                send(asta_pkg::op_t'($urandom_range(1, 3)), $urandom_range(0, 1023),
                     $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, both formula sets, both mating modes, clamping, all ops.
        send(asta_pkg::OP_UPDATE, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_UPDATE, 0, 1, 1, 1, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE,
             PROB_ONE);
        send(asta_pkg::OP_UPDATE, 0, 2, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF);
        send(asta_pkg::OP_UPDATE, 0, 3, 0, 0, PROB_ONE, 0, 0, 0, 0);
        send(asta_pkg::OP_UPDATE, 1023, 3, 0, 1, 0, 16'hFFFF, PROB_ONE, PROB_ONE, 16'hFFFF);
        send(asta_pkg::OP_UPDATE, 1023, 3, 1, 0, PROB_ONE, 0, PROB_ONE, 0, 0);
        send(asta_pkg::OP_UPDATE, 1023, 0, 1, 1, 0, PROB_ONE, 0, 0, PROB_ONE);
        send(asta_pkg::OP_UPDATE, 1023, 0, 0, 0, 16'h8001, 16'h7FFF, 16'h5555, 16'hAAAA,
             16'h1234);
        send(asta_pkg::OP_ACCUM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_ACCUM, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_ACCUM, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 0, 2, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 0, 3, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 1023, 3, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_ACCUM, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 1023, 3, 0, 0, 0, 0, 0, 0, 0);
        send(asta_pkg::OP_READ, 512, 2, 0, 0, 0, 0, 0, 0, 0);

        run_random();

        s_tvalid <= 1'b0;
        while (pending_reads != 0) @(posedge aclk);
        repeat (5000) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/asta_pkg.sv
hdl/asta_ram.sv
hdl/asta_div.sv
hdl/asta_front.sv
hdl/asta_back.sv
hdl/ancestry_score_test_accumulator_unit.sv
dv/asta_checker.sv
dv/tb_top.sv
